@@ rtl/stb_pkg.sv @@
`default_nettype none
package stb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W      = 16;
	localparam int ID_W       = 8;
	localparam int CMD_W      = 3;

	localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START_ONCE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_START_AUTO = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STOP       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CHECK      = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [ID_W-1:0]  timer_id;
		logic [CNT_W-1:0] period;
	} in_item_t;

	typedef struct packed {
		logic expired;
		logic bad_id;
	} out_item_t;

	// result of the shared count unit for one timer
	typedef struct packed {
		logic             active;
		logic             hit;
		logic [CNT_W-1:0] next_count;
	} count_res_t;

endpackage
`default_nettype wire

@@ rtl/stb_ram.sv @@
`default_nettype none
module stb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

@@ rtl/stb_count_unit.sv @@
`default_nettype none
module stb_count_unit
	import stb_pkg::*;
(
	input  wire logic [CNT_W-1:0] count,
	input  wire logic [CNT_W-1:0] reload,
	input  wire logic             auto_mode,
	output count_res_t            res
);

	logic [CNT_W-1:0] dec;

	assign dec = count - CNT_W'(1);

	always_comb begin
		res.active     = (count != '0);
		res.hit        = (count == CNT_W'(1));
		// reload an auto timer on expiry, otherwise drop to idle
		if (res.hit) begin
			res.next_count = auto_mode ? reload : '0;
		end else begin
			res.next_count = dec;
		end
	end

endmodule
`default_nettype wire

@@ rtl/soft_timer_bank_unit.sv @@
`default_nettype none
// Bank of NUM_TIMERS down-counting timers driven by a command stream.
// Input channel in_valid/in_ready/in_item carries one command per transfer:
// tick, start one-shot, start auto-reload, stop or check. Output channel
// out_valid/out_ready/out_item returns exactly one result per command:
// expired (check only) and bad_id (start, stop or check with a timer id not below NUM_TIMERS).
// For start, stop, check and unknown commands the result is
// registered and shows on the cycle after the transfer.
// A tick walks the timers one at a time through a single decrement unit
// and a shared count/reload RAM: each timer passes a RAM read state, then
// an update and write-back state, and the tick's result is registered
// after the last timer. in_ready is low throughout the walk.
// A new command is taken while a result waits only if that result is
// taken in the same cycle; a stalled receiver holds the block off.
// Reset clears all counts, flags and modes at once through per-timer
// valid bits; the RAM itself needs no clearing pass.
module soft_timer_bank_unit
	import stb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]            state_q;
	logic [IDX_W-1:0]      idx_q;
	logic [NUM_TIMERS-1:0] valid_q;
	logic [NUM_TIMERS-1:0] flag_q;
	logic [NUM_TIMERS-1:0] mode_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  accept;
	logic                  bad;
	logic [IDX_W-1:0]      id_idx;
	logic                  is_start;
	logic                  last_idx;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_wa;
	logic [2*CNT_W-1:0]    ram_wd;
	logic [2*CNT_W-1:0]    ram_rd;
	logic [CNT_W-1:0]      cur_count;
	count_res_t            cres;

	logic                  res_load;
	out_item_t             res;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign bad       = ({1'b0, in_item.timer_id} >= (ID_W+1)'(NUM_TIMERS));
	assign id_idx    = in_item.timer_id[IDX_W-1:0];
	assign is_start  = (in_item.command == CMD_START_ONCE) ||
	                   (in_item.command == CMD_START_AUTO);
	assign last_idx  = (idx_q == IDX_W'(NUM_TIMERS - 1));
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// a timer never written reads as idle
	assign cur_count = valid_q[idx_q] ? ram_rd[CNT_W-1:0] : '0;

	stb_count_unit u_count (
		.count     (cur_count),
		.reload    (ram_rd[2*CNT_W-1:CNT_W]),
		.auto_mode (mode_q[idx_q]),
		.res       (cres)
	);

	always_comb begin
		if (state_q == ST_UPD) begin
			ram_we = cres.active;
			ram_wa = idx_q;
			ram_wd = {ram_rd[2*CNT_W-1:CNT_W], cres.next_count};
		end else begin
			ram_we = accept && is_start && !bad;
			ram_wa = id_idx;
			ram_wd = {in_item.period, in_item.period};
		end
	end

	stb_ram #(
		.WIDTH (2*CNT_W),
		.DEPTH (NUM_TIMERS)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_addr (idx_q),
		.rd_data (ram_rd)
	);

	always_comb begin
		res_load    = 1'b0;
		res.expired = 1'b0;
		res.bad_id  = 1'b0;
		if (state_q == ST_UPD && last_idx) begin
			res_load = 1'b1;
		end else if (accept && in_item.command != CMD_TICK) begin
			res_load = 1'b1;
			case (in_item.command)
				CMD_START_ONCE, CMD_START_AUTO, CMD_STOP: begin
					res.bad_id = bad;
				end
				CMD_CHECK: begin
					res.bad_id  = bad;
					res.expired = !bad && flag_q[id_idx];
				end
				default: begin
					res.bad_id = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			valid_q <= '0;
			flag_q  <= '0;
			mode_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_item.command)
							CMD_TICK: begin
								idx_q   <= '0;
								state_q <= ST_RD;
							end
							CMD_START_ONCE, CMD_START_AUTO: begin
								if (!bad) begin
									valid_q[id_idx] <= 1'b1;
									flag_q[id_idx]  <= 1'b0;
									mode_q[id_idx]  <= (in_item.command == CMD_START_AUTO);
								end
							end
							CMD_STOP: begin
								if (!bad) begin
									valid_q[id_idx] <= 1'b0;
									flag_q[id_idx]  <= 1'b0;
									mode_q[id_idx]  <= 1'b0;
								end
							end
							CMD_CHECK: begin
								if (!bad) begin
									flag_q[id_idx] <= 1'b0;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (cres.active) begin
						valid_q[idx_q] <= 1'b1;
						if (cres.hit) begin
							flag_q[idx_q] <= 1'b1;
						end
					end
					if (last_idx) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	// the output register is free for the whole walk of a tick
	a_walk_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("result pending during tick walk");

	a_walk_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ({1'b0, idx_q} < (IDX_W+1)'(NUM_TIMERS)))
		else $error("walk index beyond bank");

	a_tick_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.command == CMD_TICK) |=> (state_q == ST_RD && idx_q == '0))
		else $error("tick did not start walk");

	a_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.command != CMD_TICK) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("command result missing");

	a_walk_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && last_idx) |=> (out_valid_q && !out_q.expired && !out_q.bad_id))
		else $error("tick result missing");

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import stb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;
	localparam logic [ID_W-1:0]  ID_TOP         = 8'hFF;
	localparam logic [CNT_W-1:0] PERIOD_TOP     = 16'hFFFF;
	localparam int               TICK_CYCLES    = 2 * NUM_TIMERS + 4;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	// timer bank as the testbench sees it
	logic [CNT_W-1:0] ticks_left [NUM_TIMERS];
	logic [CNT_W-1:0] reload_ticks [NUM_TIMERS];
	logic             expiry_seen [NUM_TIMERS];
	logic             auto_reload [NUM_TIMERS];

	out_item_t pending_results [$];
	int        failures = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;

	soft_timer_bank_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic clear_timer_bank();
		for (int t = 0; t < NUM_TIMERS; t++) begin
			ticks_left[t]   = '0;
			reload_ticks[t] = '0;
			expiry_seen[t]  = 1'b0;
			auto_reload[t]  = 1'b0;
		end
	endtask

	function automatic out_item_t timer_bank_result(input in_item_t item);
		out_item_t res;
		int        id;
		res = '0;
		id  = int'(item.timer_id);
		case (item.command)
			CMD_TICK: begin
				for (int t = 0; t < NUM_TIMERS; t++) begin
					if (ticks_left[t] != '0) begin
						ticks_left[t] = ticks_left[t] - 1'b1;
						if (ticks_left[t] == '0) begin
							expiry_seen[t] = 1'b1;
							if (auto_reload[t])
								ticks_left[t] = reload_ticks[t];
						end
					end
				end
			end
			CMD_START_ONCE, CMD_START_AUTO, CMD_STOP, CMD_CHECK: begin
				if (id >= NUM_TIMERS) begin
					res.bad_id = 1'b1;
				end else if (item.command == CMD_STOP) begin
					ticks_left[id]  = '0;
					expiry_seen[id] = 1'b0;
					auto_reload[id] = 1'b0;
				end else if (item.command == CMD_CHECK) begin
					res.expired     = expiry_seen[id];
					expiry_seen[id] = 1'b0;
				end else begin
					ticks_left[id]   = item.period;
					reload_ticks[id] = item.period;
					expiry_seen[id]  = 1'b0;
					auto_reload[id]  = (item.command == CMD_START_AUTO);
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic in_item_t timer_cmd(input logic [CMD_W-1:0] command,
			input logic [ID_W-1:0] timer_id, input logic [CNT_W-1:0] period);
		in_item_t item;
		item.command  = command;
		item.timer_id = timer_id;
		item.period   = period;
		return item;
	endfunction

	function automatic in_item_t random_timer_cmd();
		in_item_t item;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 35)
			item.command = CMD_TICK;
		else if (pick < 50)
			item.command = CMD_START_ONCE;
		else if (pick < 65)
			item.command = CMD_START_AUTO;
		else if (pick < 74)
			item.command = CMD_STOP;
		else if (pick < 95)
			item.command = CMD_CHECK;
		else
			item.command = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
		// mostly live timers, some ids beyond the bank
		if ($urandom_range(99) < 85)
			item.timer_id = ID_W'($urandom_range(NUM_TIMERS - 1));
		else
			item.timer_id = ID_W'($urandom_range(ID_TOP));
		pick = $urandom_range(99);
		if (pick < 70)
			item.period = CNT_W'($urandom_range(1, 12));
		else if (pick < 78)
			item.period = '0;
		else
			item.period = CNT_W'($urandom_range(PERIOD_TOP));
		return item;
	endfunction

	task automatic send_command(input in_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item  <= item;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(timer_bank_result(item));
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("result with nothing pending: expired %b bad_id %b",
					out_item.expired, out_item.bad_id));
			end else begin
				want = pending_results.pop_front();
				if (out_item.expired !== want.expired || out_item.bad_id !== want.bad_id)
					note_failure($sformatf("expired %b bad_id %b, wanted expired %b bad_id %b",
						out_item.expired, out_item.bad_id, want.expired, want.bad_id));
			end
		end
	end

	task automatic test_directed_commands();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_command(timer_cmd(CMD_CHECK, 8'd0, '0));
		// one-shot of one tick, flag clears on the first check
		send_command(timer_cmd(CMD_START_ONCE, 8'd0, 16'd1));
		send_command(timer_cmd(CMD_TICK, 8'd0, '0));
		send_command(timer_cmd(CMD_CHECK, 8'd0, '0));
		send_command(timer_cmd(CMD_CHECK, 8'd0, '0));
		// auto-reload on the highest timer expires every second tick
		send_command(timer_cmd(CMD_START_AUTO, ID_W'(NUM_TIMERS - 1), 16'd2));
		send_command(timer_cmd(CMD_TICK, ID_TOP, PERIOD_TOP));
		send_command(timer_cmd(CMD_TICK, 8'd0, '0));
		send_command(timer_cmd(CMD_CHECK, ID_W'(NUM_TIMERS - 1), '0));
		send_command(timer_cmd(CMD_TICK, 8'd0, '0));
		send_command(timer_cmd(CMD_TICK, 8'd0, '0));
		send_command(timer_cmd(CMD_CHECK, ID_W'(NUM_TIMERS - 1), '0));
		// zero period stays idle
		send_command(timer_cmd(CMD_START_ONCE, 8'd1, '0));
		send_command(timer_cmd(CMD_START_ONCE, 8'd2, PERIOD_TOP));
		send_command(timer_cmd(CMD_TICK, 8'd0, '0));
		send_command(timer_cmd(CMD_CHECK, 8'd1, '0));
		send_command(timer_cmd(CMD_STOP, ID_W'(NUM_TIMERS - 1), '0));
		send_command(timer_cmd(CMD_CHECK, ID_W'(NUM_TIMERS - 1), '0));
		// ids beyond the bank change nothing
		send_command(timer_cmd(CMD_START_ONCE, ID_W'(NUM_TIMERS), 16'd1));
		send_command(timer_cmd(CMD_START_AUTO, 8'h80, 16'd1));
		send_command(timer_cmd(CMD_STOP, ID_TOP, '0));
		send_command(timer_cmd(CMD_CHECK, ID_TOP, PERIOD_TOP));
		send_command(timer_cmd(CMD_RSVD_FIRST, 8'd0, 16'd1));
		send_command(timer_cmd(CMD_RSVD_LAST, ID_TOP, PERIOD_TOP));
		wait_results_drained();
	endtask

	task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n)
			send_command(random_timer_cmd());
		wait_results_drained();
	endtask

	task automatic test_pause_until_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 50;
		repeat (20)
			send_command(random_timer_cmd());
		// hold the sender off until every result is back, then resume
		wait_results_drained();
		repeat (20)
			send_command(random_timer_cmd());
		wait_results_drained();
	endtask

	initial begin
		clear_timer_bank();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_commands();
		test_random_traffic(180, 0, 0);
		test_random_traffic(140, 87, 0);
		test_random_traffic(140, 0, 87);
		test_pause_until_drained();
		test_random_traffic(150, 8, 8);
		recv_stall_pct = 0;
		repeat (TICK_CYCLES)
			@(posedge clk);
		if (failures == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
